[src/hbc_pkg.sv]
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants of the hashed buffer cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none
package hbc_pkg;
    localparam int ENTRIES     = 32;
    localparam int BUCKETS     = 13;
    localparam int DEVICE_BITS = 8;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CNT_W       = IDX_W + 1;

    // reciprocal of BUCKETS, rounded up, exact for every 32 bit key
    localparam int          BKT_SH  = 32 + $clog2(BUCKETS);
    localparam logic [32:0] BKT_RCP =
        33'(((64'd1 << BKT_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    localparam logic [1:0] FUNC_GET     = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_PIN     = 2'd2;
    localparam logic [1:0] FUNC_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBUF = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    localparam logic [7:0]  COUNT_MAX = 8'hff;
    localparam logic [31:0] NO_TIME   = 32'hffff_ffff;

    // one entry of the cache
    typedef struct packed {
        logic [7:0]       dev;
        logic [31:0]      blk;
        logic [7:0]       cnt;
        logic [31:0]      tim;
        logic             vld;
        logic [IDX_W-1:0] rank;
        logic [BKT_W-1:0] bkt;
    } t_entry;

    // bucket of a 32 bit key: quotient by reciprocal multiply, remainder as key minus quotient times BUCKETS
    function automatic logic [BKT_W-1:0] bucket_of(input logic [31:0] key);
        logic [64:0] prod;
        logic [31:0] quo;
        logic [31:0] back;
        prod = 65'(key) * 65'(BKT_RCP);
        quo  = 32'(prod >> BKT_SH);
        back = quo * 32'(BUCKETS);
        return BKT_W'(key - back);
    endfunction
endpackage
`default_nettype wire

[src/hbc_cell.sv]
// ----------------------------------------------------------------------------
// hbc_cell
// One storage cell of the ring: holds an entry, passes it on when shifting;
// the tail cell takes the updated head entry when a write is requested.
// ----------------------------------------------------------------------------
`default_nettype none
module hbc_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire hbc_pkg::t_entry i_rst_val,
    input  wire                  i_shift,
    input  wire hbc_pkg::t_entry i_prev,
    input  wire                  i_wr,
    input  wire hbc_pkg::t_entry i_wr_val,
    output hbc_pkg::t_entry      o_q
);
    import hbc_pkg::*;
    t_entry r_q;
    t_entry n_q;

    // next value: write wins, else shift
    always_comb begin
        n_q = r_q;
        if (i_wr) n_q = i_wr_val;
        else if (i_shift) n_q = i_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q <= i_rst_val;
        else r_q <= n_q;
    end
    assign o_q = r_q;
endmodule
`default_nettype wire

[src/hashed_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// hashed_buffer_cache_lru
// Tag and replacement controller of a hashed-bucket disk block cache.
// ----------------------------------------------------------------------------
// Entries sit in a ring of cells that rotates one place per cycle during a
// pass. After the request is hashed in S_HASH, a get rotates the ring once to
// search and a second time to apply the update and rank move; busy stays high
// from S_HASH through S_DONE. Release, pin and unpin use one rotation, except
// a release that drops the count to zero: it takes a second turn to bump the
// ranks of the entries ahead of it.
// The result strobe o_done lasts one cycle, right after busy falls, and a new
// command can be accepted in that cycle; the receiver cannot stall.
`default_nettype none
module hashed_buffer_cache_lru (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [1:0]                  i_func,
    input  wire  [7:0]                  i_dev_number,
    input  wire  [31:0]                 i_block_number,
    input  wire  [4:0]                  i_buffer_index,
    input  wire  [31:0]                 i_tick_now,
    output logic                        o_done,
    output logic [4:0]                  o_buffer_slot,
    output logic                        o_was_cached,
    output logic                        o_needs_read,
    output logic [1:0]                  o_status
);
    import hbc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;   // position counter: cell 0 holds entry r_cnt
    logic [1:0]       r_func;
    logic [7:0]       r_dev;
    logic [31:0]      r_blk, r_now;
    logic [IDX_W-1:0] r_idx;
    logic             r_idx_ok;
    logic [BKT_W-1:0] r_bkt, n_bkt;
    // search results
    logic             r_hit, n_hit;
    logic [IDX_W-1:0] r_hpos, n_hpos, r_hrank, n_hrank;
    logic             r_loc, n_loc;
    logic [IDX_W-1:0] r_lpos, n_lpos, r_lrank, n_lrank;
    logic             r_stl, n_stl;
    logic [IDX_W-1:0] r_spos, n_spos, r_srank, n_srank;
    logic [31:0]      r_stim, n_stim;
    logic [BKT_W-1:0] r_sbkt, n_sbkt;
    // apply decisions
    logic             r_mv, n_mv;           // target moves to rank 0
    logic [IDX_W-1:0] r_tpos, n_tpos, r_trank, n_trank;
    logic             r_act, n_act;
    logic [1:0]       r_stat, n_stat;
    logic             r_cach, n_cach, r_nr, n_nr;
    logic             r_done, n_done;

    t_entry q [ENTRIES];
    t_entry wv;
    logic   wr;
    logic   shift;

    // ring of cells, entry i lives in cell i when idle
    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            t_entry rv;
            always_comb begin
                rv = '0;
                rv.rank = IDX_W'(ENTRIES - 1 - g);
                rv.bkt  = bucket_of(32'd0);
            end
            if (g == ENTRIES - 1) begin : g_tail
                // the entry leaving the head comes in here, updated when wr is high
                hbc_cell u_cell (.i_clk, .i_rst_n, .i_rst_val(rv), .i_shift(shift),
                    .i_prev(q[0]), .i_wr(wr), .i_wr_val(wv), .o_q(q[g]));
            end else begin : g_body
                hbc_cell u_cell (.i_clk, .i_rst_n, .i_rst_val(rv), .i_shift(shift),
                    .i_prev(q[g + 1]), .i_wr(1'b0), .i_wr_val(q[0]),
                    .o_q(q[g]));
            end
        end
    endgenerate

    t_entry h;
    logic [IDX_W-1:0] pos;
    assign h   = q[0];
    assign pos = r_cnt[IDX_W-1:0];

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_bkt = r_bkt;
        n_hit = r_hit; n_hpos = r_hpos; n_hrank = r_hrank;
        n_loc = r_loc; n_lpos = r_lpos; n_lrank = r_lrank;
        n_stl = r_stl; n_spos = r_spos; n_srank = r_srank;
        n_stim = r_stim; n_sbkt = r_sbkt;
        n_mv = r_mv; n_tpos = r_tpos; n_trank = r_trank; n_act = r_act;
        n_stat = r_stat; n_cach = r_cach; n_nr = r_nr; n_done = 1'b0;
        shift = 1'b0; wr = 1'b0; wv = h;
        case (r_st)
            S_IDLE: begin
                if (start) n_st = S_HASH;
            end
            // request bucket, clear search
            S_HASH: begin
                n_bkt = bucket_of(r_dev + r_blk);
                n_hit = 1'b0; n_loc = 1'b0; n_stl = 1'b0; n_stim = NO_TIME;
                n_cnt = '0; n_stat = ST_OK; n_cach = 1'b0; n_nr = 1'b0;
                n_mv = 1'b0; n_act = 1'b0;
                if (r_func == FUNC_GET) n_st = S_SCAN;
                else begin
                    n_act = r_idx_ok; n_tpos = r_idx; n_st = S_APPLY;
                end
            end
            // search pass over the head cell
            S_SCAN: begin
                shift = 1'b1;
                if (h.bkt == r_bkt && h.dev == r_dev && h.blk == r_blk &&
                    (!r_hit || h.rank < r_hrank)) begin
                    n_hit = 1'b1; n_hpos = pos; n_hrank = h.rank;
                end
                if (h.cnt == 8'd0 && h.bkt == r_bkt && (!r_loc || h.rank > r_lrank)) begin
                    n_loc = 1'b1; n_lpos = pos; n_lrank = h.rank;
                end
                if (h.cnt == 8'd0 && h.bkt != r_bkt && h.tim != NO_TIME &&
                    (!r_stl || h.tim < r_stim || (h.tim == r_stim && h.bkt < r_sbkt) ||
                     (h.tim == r_stim && h.bkt == r_sbkt && h.rank > r_srank))) begin
                    n_stl = 1'b1; n_spos = pos; n_stim = h.tim;
                    n_sbkt = h.bkt; n_srank = h.rank;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ENTRIES - 1)) begin
                    n_cnt = '0; n_st = S_APPLY; n_act = 1'b1;
                    if (n_hit) begin
                        n_tpos = n_hpos; n_cach = 1'b1;
                    end else if (n_loc) begin
                        n_tpos = n_lpos; n_trank = n_lrank; n_mv = 1'b1; n_nr = 1'b1;
                    end else if (n_stl) begin
                        n_tpos = n_spos; n_trank = n_srank; n_mv = 1'b1; n_nr = 1'b1;
                    end else begin
                        n_act = 1'b0; n_stat = ST_NOBUF; n_tpos = '0;
                    end
                end
            end
            // apply pass: update target at head, shift ranks of other entries as they pass
            S_APPLY: begin
                shift = 1'b1;
                if (r_act && pos == r_tpos) begin
                    wr = 1'b1;
                    if (r_func == FUNC_GET) begin
                        wv.tim = r_now; wv.vld = 1'b1;
                        if (r_cach) begin
                            n_nr = ~h.vld;
                            if (h.cnt == COUNT_MAX) n_stat = ST_OVER;
                            else wv.cnt = h.cnt + 8'd1;
                        end else begin
                            wv.dev = r_dev; wv.blk = r_blk; wv.cnt = 8'd1;
                            wv.bkt = r_bkt; wv.rank = '0;
                        end
                    end else if (r_func == FUNC_PIN) begin
                        if (h.cnt == COUNT_MAX) n_stat = ST_OVER;
                        else wv.cnt = h.cnt + 8'd1;
                    end else if (h.cnt == 8'd0) begin
                        n_stat = ST_UNDER;
                    end else begin
                        wv.cnt = h.cnt - 8'd1;
                        if (r_func == FUNC_RELEASE) begin
                            wv.tim = r_now;
                            if (h.cnt == 8'd1) begin
                                wv.rank = '0;
                                // entries ahead of the target are bumped on a second turn
                                n_mv = 1'b1; n_trank = h.rank;
                            end
                        end
                    end
                end else if (r_mv && h.rank < r_trank &&
                             (!r_cnt[IDX_W] || pos < r_tpos)) begin
                    wr = 1'b1; wv.rank = h.rank + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2*ENTRIES - 1) ||
                    (r_cnt == CNT_W'(ENTRIES - 1) && !(n_mv && r_func != FUNC_GET)))
                begin
                    n_st = S_DONE; n_cnt = '0;
                end
            end
            S_DONE: begin
                n_done = 1'b1; n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    // r_act is cleared once the target is written, so the target is updated only once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_done <= 1'b0; r_act <= 1'b0; r_mv <= 1'b0;
            r_hit <= 1'b0; r_loc <= 1'b0; r_stl <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_done <= n_done;
            r_act <= (r_st == S_APPLY && r_act && pos == r_tpos) ? 1'b0 : n_act;
            r_mv <= n_mv;
            r_hit <= n_hit; r_loc <= n_loc; r_stl <= n_stl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_func <= i_func; r_dev <= 8'(i_dev_number & 8'((1 << DEVICE_BITS) - 1));
            r_blk <= i_block_number; r_now <= i_tick_now;
            r_idx <= IDX_W'(i_buffer_index);
            r_idx_ok <= (32'(i_buffer_index) < 32'(ENTRIES));
            o_buffer_slot <= i_buffer_index;
        end else if (r_st == S_SCAN && n_st == S_APPLY) begin
            o_buffer_slot <= 5'(n_tpos);
        end
        r_bkt <= n_bkt; r_hpos <= n_hpos; r_hrank <= n_hrank;
        r_lpos <= n_lpos; r_lrank <= n_lrank; r_spos <= n_spos; r_srank <= n_srank;
        r_stim <= n_stim; r_sbkt <= n_sbkt; r_tpos <= n_tpos; r_trank <= n_trank;
        r_stat <= n_stat; r_cach <= n_cach; r_nr <= n_nr;
    end

    assign busy         = (r_st != S_IDLE);
    assign o_done       = r_done;
    assign o_was_cached = r_cach;
    assign o_needs_read = r_nr;
    assign o_status     = r_stat;

    // assertions
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("strobe while busy");
    a_nobuf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NOBUF) |-> (!o_needs_read && !o_was_cached))
        else $error("no buffer with flags");
    a_cached_nr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_needs_read && !o_was_cached) |-> o_status == ST_OK)
        else $error("miss with bad status");
endmodule
`default_nettype wire

[dv/tb_hashed_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// tb_hashed_buffer_cache_lru
// Self-checking bench for the buffer cache tag controller: a queue-fed driver
// issues get/release/pin/unpin commands in bursts, a scoreboard model predicts
// every result and a monitor compares each strobed result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_hashed_buffer_cache_lru;
    import hbc_pkg::*;

    // one command transaction
    typedef struct {
        logic [1:0]  func;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [4:0]  idx;
        logic [31:0] tick;
    } t_cmd;

    // one result transaction
    typedef struct {
        logic [4:0] slot;
        logic       cached;
        logic       rd;
        logic [1:0] status;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [7:0]  i_dev_number;
    logic [31:0] i_block_number;
    logic [4:0]  i_buffer_index;
    logic [31:0] i_tick_now;
    logic        o_done;
    logic [4:0]  o_buffer_slot;
    logic        o_was_cached;
    logic        o_needs_read;
    logic [1:0]  o_status;

    hashed_buffer_cache_lru uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_dev_number(i_dev_number),
        .i_block_number(i_block_number), .i_buffer_index(i_buffer_index),
        .i_tick_now(i_tick_now), .o_done(o_done), .o_buffer_slot(o_buffer_slot),
        .o_was_cached(o_was_cached), .o_needs_read(o_needs_read),
        .o_status(o_status)
    );

    // model state of the cache
    logic [7:0]  m_dev  [ENTRIES];
    logic [31:0] m_blk  [ENTRIES];
    logic [7:0]  m_cnt  [ENTRIES];
    logic [31:0] m_tim  [ENTRIES];
    logic        m_vld  [ENTRIES];
    int          m_rank [ENTRIES];

    t_cmd cmd_q[$];
    t_res expected_q[$];
    int   errors = 0;
    int   cycles = 0;
    bit   hold_off = 0;
    int   gap_left = 0;
    int   burst_left = 0;
    logic busy_at_rise;

    localparam int CYCLE_LIMIT = 400000;

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int key_bucket(input logic [7:0] d, input logic [31:0] b);
        logic [31:0] k;
        k = 32'(d) + b;
        return int'(k % BUCKETS);
    endfunction

    function automatic void move_front(input int e);
        int r;
        r = m_rank[e];
        for (int j = 0; j < ENTRIES; j++)
            if (m_rank[j] < r) m_rank[j]++;
        m_rank[e] = 0;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            m_dev[i] = '0; m_blk[i] = '0; m_cnt[i] = '0; m_tim[i] = '0;
            m_vld[i] = 1'b0; m_rank[i] = ENTRIES - 1 - i;
        end
    endfunction

    // predicted result of one command, updates the model state
    function automatic t_res predict_cache(input t_cmd c);
        t_res r;
        int v, pick, bt, bb, b;
        r = '{slot: '0, cached: 1'b0, rd: 1'b0, status: ST_OK};
        pick = -1;
        if (c.func == FUNC_GET) begin
            v = key_bucket(c.dev, c.blk);
            for (int i = 0; i < ENTRIES; i++)
                if (m_dev[i] == c.dev && m_blk[i] == c.blk &&
                    (pick < 0 || m_rank[i] < m_rank[pick])) pick = i;
            if (pick >= 0) begin
                r.slot = 5'(pick); r.cached = 1'b1; r.rd = !m_vld[pick];
                if (m_cnt[pick] == COUNT_MAX) r.status = ST_OVER;
                else m_cnt[pick]++;
                m_tim[pick] = c.tick; m_vld[pick] = 1'b1;
                return r;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (m_cnt[i] == 0 && key_bucket(m_dev[i], m_blk[i]) == v &&
                    (pick < 0 || m_rank[i] > m_rank[pick])) pick = i;
            if (pick < 0) begin
                bt = 0; bb = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    b = key_bucket(m_dev[i], m_blk[i]);
                    if (m_cnt[i] != 0 || b == v || m_tim[i] == NO_TIME) continue;
                    if (pick < 0 || m_tim[i] < 32'(bt) ||
                        (m_tim[i] == 32'(bt) && b < bb) ||
                        (m_tim[i] == 32'(bt) && b == bb && m_rank[i] > m_rank[pick]))
                    begin
                        pick = i; bt = int'(m_tim[i]); bb = b;
                    end
                end
            end
            if (pick < 0) begin
                r.status = ST_NOBUF;
                return r;
            end
            m_dev[pick] = c.dev; m_blk[pick] = c.blk; m_cnt[pick] = 8'd1;
            m_tim[pick] = c.tick; move_front(pick); m_vld[pick] = 1'b1;
            r.slot = 5'(pick); r.rd = 1'b1;
            return r;
        end
        r.slot = c.idx;
        if (int'(c.idx) >= ENTRIES) return r;
        if (c.func == FUNC_PIN) begin
            if (m_cnt[c.idx] == COUNT_MAX) r.status = ST_OVER;
            else m_cnt[c.idx]++;
            return r;
        end
        if (m_cnt[c.idx] == 0) begin
            r.status = ST_UNDER;
            return r;
        end
        m_cnt[c.idx]--;
        if (c.func == FUNC_RELEASE) begin
            if (m_cnt[c.idx] == 0) move_front(int'(c.idx));
            m_tim[c.idx] = c.tick;
        end
        return r;
    endfunction

    // command helpers
    function automatic t_cmd mk(input logic [1:0] f, input logic [7:0] d,
                                input logic [31:0] b, input logic [4:0] x,
                                input logic [31:0] t);
        t_cmd c;
        c.func = f; c.dev = d; c.blk = b; c.idx = x; c.tick = t;
        return c;
    endfunction

    // busy as seen at the last rising edge
    always @(posedge i_clk) busy_at_rise <= busy;

    // driver: bursts and gaps, drives at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !busy_at_rise) begin
            // previous transaction was accepted at the last rising edge
            start <= next_start();
        end else if (!start) begin
            start <= next_start();
        end
    end

    function automatic logic next_start();
        t_cmd c;
        if (cmd_q.size() == 0 || hold_off) return 1'b0;
        if (gap_left > 0) begin
            gap_left--;
            return 1'b0;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(0, 90);
            if (gap_left > 0) return 1'b0;
        end
        burst_left--;
        c = cmd_q.pop_front();
        i_func = c.func; i_dev_number = c.dev; i_block_number = c.blk;
        i_buffer_index = c.idx; i_tick_now = c.tick;
        expected_q.push_back(predict_cache(c));
        return 1'b1;
    endfunction

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_res e;
        cycles++;
        if (i_rst_n && o_done) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 32'(o_buffer_slot), 32'h0);
            end else begin
                e = expected_q.pop_front();
                if (o_buffer_slot !== e.slot)
                    report("buffer_slot", 32'(o_buffer_slot), 32'(e.slot));
                if (o_was_cached !== e.cached)
                    report("was_cached", 32'(o_was_cached), 32'(e.cached));
                if (o_needs_read !== e.rd)
                    report("needs_read", 32'(o_needs_read), 32'(e.rd));
                if (o_status !== e.status)
                    report("status", 32'(o_status), 32'(e.status));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_hashed_buffer_cache_lru: done, errors");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_cmd c;
        int n;
        logic [31:0] tick;
        i_rst_n = 1'b0; start = 1'b0;
        i_func = FUNC_GET; i_dev_number = '0; i_block_number = '0;
        i_buffer_index = '0; i_tick_now = '0;
        cache_reset();
        tick = 32'd100;

        // directed: hits, misses, steal, extremes, count limits
        cmd_q.push_back(mk(FUNC_GET, 8'd0, 32'd0, 5'd0, 32'd5));          // hit on reset tag
        cmd_q.push_back(mk(FUNC_GET, 8'hff, 32'hffffffff, 5'd31, 32'hffffffff));
        cmd_q.push_back(mk(FUNC_GET, 8'd1, 32'd12, 5'd0, 32'd7));         // same bucket as 0
        cmd_q.push_back(mk(FUNC_GET, 8'd3, 32'd4, 5'd0, 32'd0));          // steal
        cmd_q.push_back(mk(FUNC_RELEASE, 8'd0, 32'd0, 5'd31, 32'd9));
        cmd_q.push_back(mk(FUNC_RELEASE, 8'd0, 32'd0, 5'd31, 32'd9));     // underflow
        cmd_q.push_back(mk(FUNC_UNPIN, 8'd0, 32'd0, 5'd5, 32'd0));        // underflow
        cmd_q.push_back(mk(FUNC_PIN, 8'd0, 32'd0, 5'd5, 32'd0));
        cmd_q.push_back(mk(FUNC_UNPIN, 8'd0, 32'd0, 5'd5, 32'd0));
        cmd_q.push_back(mk(FUNC_RELEASE, 8'hff, 32'hffffffff, 5'd0, 32'hffffffff));
        cmd_q.push_back(mk(FUNC_GET, 8'h80, 32'h80000000, 5'd0, 32'h12345678));
        cmd_q.push_back(mk(FUNC_PIN, 8'd0, 32'd0, 5'd0, 32'd0));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // pin one entry up to full count and beyond
        while (cmd_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        for (int i = 0; i < 257; i++)
            cmd_q.push_back(mk(FUNC_PIN, 8'd0, 32'd0, 5'd7, 32'd0));
        cmd_q.push_back(mk(FUNC_GET, m_dev[7], m_blk[7], 5'd0, 32'd44)); // hit at full
        while (cmd_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);

        // fill: exhaust free entries to reach no free buffer
        for (int i = 0; i < 40; i++)
            cmd_q.push_back(mk(FUNC_GET, 8'(i), 32'($urandom), 5'd0, 32'(i + 1)));
        while (cmd_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);

        // pause until idle, then random mix
        hold_off = 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
        for (int k = 0; k < 140; k++) begin
            tick = tick + $urandom_range(0, 3);
            n = $urandom_range(0, 99);
            if (n < 45)
                c = mk(FUNC_GET, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, 3)),
                       ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 40)),
                       5'($urandom), ($urandom_range(0, 30) == 0) ? 32'hffffffff : tick);
            else if (n < 75)
                c = mk(FUNC_RELEASE, 8'($urandom), $urandom, 5'($urandom), tick);
            else if (n < 87)
                c = mk(FUNC_PIN, 8'($urandom), $urandom, 5'($urandom), $urandom);
            else
                c = mk(FUNC_UNPIN, 8'($urandom), $urandom, 5'($urandom), $urandom);
            cmd_q.push_back(c);
        end
        while (cmd_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * ENTRIES + 20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb_hashed_buffer_cache_lru: done, clean");
        else
            $display("tb_hashed_buffer_cache_lru: done, errors");
        $finish;
    end
endmodule
